@@ rtl/char_lcd_4bit_interface_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 4-bit character LCD interface
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_INTERFACE_MACROS_SVH
`define CHAR_LCD_4BIT_INTERFACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLCD4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLCD4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/clcd4_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd4_pkg
// Codes, widths and constants of the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd4_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 3'd0,
        FN_CMD    = 3'd1,
        FN_DATA   = 3'd2,
        FN_CURSOR = 3'd3,
        FN_CLEAR  = 3'd4,
        FN_INIT   = 3'd5
    } func_t;

    typedef enum logic [IDX_W-1:0] {
        REG_POWER_ON  = 2'd0,
        REG_EN_HIGH   = 2'd1,
        REG_EN_LOW    = 2'd2,
        REG_SETTLE    = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [7:0] POWER_ON_RST = 8'd50;
    localparam logic [3:0] EN_HIGH_RST  = 4'd1;
    localparam logic [3:0] EN_LOW_RST   = 4'd1;
    localparam logic [3:0] SETTLE_RST   = 4'd2;

    // Controller commands and wake-up nibbles
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] ROW0_BASE    = 8'h80;
    localparam logic [7:0] ROW1_BASE    = 8'hC0;
    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_4BIT     = 4'h2;
    localparam logic [7:0] WAIT_WAKE1   = 8'd5;
    localparam logic [7:0] WAIT_WAKE2   = 8'd1;

    function automatic logic [7:0] init_cmd(input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0:    c = CMD_FUNC_SET;
            2'd1:    c = CMD_DISP_ON;
            2'd2:    c = CMD_ENTRY;
            default: c = CMD_CLEAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_4bit_interface.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface
// Tick-driven pin sequencer for a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// Path: an input transfer is registered in the input stage, then its result in
//   the result stage; one sequencer update sits between the two.
// Throughput: one item per cycle unless the result stalls; combinational update.
// Reset: rst_n clears both stages, the sequencer (idle, all pins low) and
//   loads the timing registers with their defaults (50, 1, 1, 2).
`default_nettype none

module char_lcd_4bit_interface
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Item stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] byte_value, [8] row, [14:9] col, [15] zero
    input  wire logic [clcd4_pkg::S_DATA_W-1:0]  s_tdata,
    // [2:0] func
    input  wire logic [clcd4_pkg::FUNC_W-1:0]    s_tuser,
    // Result stream out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] rs_level, [1] en_level, [5:2] nibble_lines, [6] busy_res, [7] accepted
    output logic [clcd4_pkg::M_DATA_W-1:0]       m_tdata,
    // Register write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [clcd4_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [clcd4_pkg::CFG_W-1:0]     cfg_data
);

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_HI_ENH    = 4'd1,
        PH_HI_ENL    = 4'd2,
        PH_LO_ENH    = 4'd3,
        PH_LO_ENL    = 4'd4,
        PH_SETTLE    = 4'd5,
        PH_INIT_WAIT = 4'd6,
        PH_INIT_ENH  = 4'd7,
        PH_INIT_ENL  = 4'd8
    } phase_t;

    // Timing register set
    typedef struct packed {
        logic [7:0] power_on;
        logic [3:0] en_high;
        logic [3:0] en_low;
        logic [3:0] settle;
    } cfg_t;

    // Full sequencer state; pins: [3:0] D4..D7, [4] EN, [5] RS
    typedef struct packed {
        phase_t     phase;
        logic [7:0] count;
        logic [7:0] byte_val;
        logic [3:0] step;
        logic       in_init;
        logic       extra;
        logic [5:0] pins;
    } seq_t;

    // A zero count register behaves as one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic seq_t start_byte(input seq_t s, input logic [7:0] b,
                                        input logic rs, input cfg_t c);
        seq_t r;
        r          = s;
        r.byte_val = b;
        r.pins     = {rs, 1'b1, b[7:4]};
        r.phase    = PH_HI_ENH;
        r.count    = at_least_one({4'd0, c.en_high});
        return r;
    endfunction

    // Power-up program, one step per entry
    function automatic seq_t enter_step(input seq_t s, input logic [3:0] st,
                                        input cfg_t c);
        seq_t       r;
        logic [3:0] cmd_sel;
        r       = s;
        r.step  = st;
        cmd_sel = st - 4'd7;
        case (st)
            4'd0:
            begin
                r.phase = PH_INIT_WAIT;
                r.count = at_least_one(c.power_on);
            end
            4'd1, 4'd3, 4'd5:
            begin
                r.pins  = {s.pins[5], 1'b1, clcd4_pkg::NIB_WAKE};
                r.phase = PH_INIT_ENH;
                r.count = at_least_one({4'd0, c.en_high});
            end
            4'd2:
            begin
                r.phase = PH_INIT_WAIT;
                r.count = clcd4_pkg::WAIT_WAKE1;
            end
            4'd4:
            begin
                r.phase = PH_INIT_WAIT;
                r.count = clcd4_pkg::WAIT_WAKE2;
            end
            4'd6:
            begin
                r.pins  = {s.pins[5], 1'b1, clcd4_pkg::NIB_4BIT};
                r.phase = PH_INIT_ENH;
                r.count = at_least_one({4'd0, c.en_high});
            end
            4'd7, 4'd8, 4'd9, 4'd10:
            begin
                r      = start_byte(r, clcd4_pkg::init_cmd(cmd_sel[1:0]), 1'b0, c);
                r.step = st;
            end
            4'd11:
            begin
                r.phase = PH_INIT_WAIT;
                r.count = at_least_one({4'd0, c.settle});
            end
            default:
            begin
                r.in_init = 1'b0;
                r.step    = 4'd0;
                r.phase   = PH_IDLE;
                r.count   = 8'd0;
            end
        endcase
        return r;
    endfunction

    // Move to the next phase once the count runs out
    function automatic seq_t advance(input seq_t s, input cfg_t c);
        seq_t r;
        r = s;
        unique case (s.phase)
            PH_HI_ENH:
            begin
                r.pins[4] = 1'b0;
                r.phase   = PH_HI_ENL;
                r.count   = at_least_one({4'd0, c.en_low});
            end
            PH_HI_ENL:
            begin
                r.pins[4:0] = {1'b1, s.byte_val[3:0]};
                r.phase     = PH_LO_ENH;
                r.count     = at_least_one({4'd0, c.en_high});
            end
            PH_LO_ENH:
            begin
                r.pins[4] = 1'b0;
                r.phase   = PH_LO_ENL;
                r.count   = at_least_one({4'd0, c.en_low});
            end
            PH_LO_ENL:
            begin
                r.phase = PH_SETTLE;
                r.count = at_least_one({4'd0, c.settle});
            end
            PH_SETTLE:
            begin
                if (s.extra)
                begin
                    r.extra = 1'b0;
                    r.count = at_least_one({4'd0, c.settle});
                end
                else if (s.in_init)
                begin
                    r = enter_step(s, s.step + 4'd1, c);
                end
                else
                begin
                    r.phase = PH_IDLE;
                    r.count = 8'd0;
                end
            end
            PH_INIT_ENH:
            begin
                r.pins[4] = 1'b0;
                r.phase   = PH_INIT_ENL;
                r.count   = at_least_one({4'd0, c.en_low});
            end
            PH_INIT_WAIT, PH_INIT_ENL:
            begin
                r = enter_step(s, s.step + 4'd1, c);
            end
            default:
            begin
                r.phase   = PH_IDLE;
                r.count   = 8'd0;
                r.in_init = 1'b0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cfg_t                cfg_reg;
    seq_t                seq_reg,  seq_next;

    logic                in_vld_reg;
    clcd4_pkg::func_t    in_func_reg;
    logic [7:0]          in_byte_reg;
    logic                in_row_reg;
    logic [5:0]          in_col_reg;

    logic                out_vld_reg;
    logic [clcd4_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                advance_en;
    logic                busy;
    logic                taken;
    logic [7:0]          cursor_addr;

    // The result stage drains or is empty: the input stage may move on
    assign advance_en = !out_vld_reg || m_tready;
    assign s_tready   = !in_vld_reg || advance_en;
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign cfg_ready  = 1'b1;

    assign busy        = (seq_reg.phase != PH_IDLE);
    assign cursor_addr = (in_row_reg ? clcd4_pkg::ROW1_BASE : clcd4_pkg::ROW0_BASE)
                         + {2'b00, in_col_reg};

    // ------------------------------------------------------------------
    // Sequencer update for the item held in the input stage
    // ------------------------------------------------------------------
    always_comb
    begin
        seq_next = seq_reg;
        taken    = 1'b0;
        unique case (in_func_reg)
            clcd4_pkg::FN_TICK:
            begin
                // Count down only while a sequence runs
                if (busy)
                begin
                    seq_next.count = seq_reg.count - 8'd1;
                    if (seq_next.count == 8'd0)
                    begin
                        seq_next = advance(seq_next, cfg_reg);
                    end
                end
            end
            clcd4_pkg::FN_CMD:
            begin
                if (!busy)
                begin
                    taken            = 1'b1;
                    seq_next.extra   = 1'b0;
                    seq_next.in_init = 1'b0;
                    seq_next = start_byte(seq_next, in_byte_reg, 1'b0, cfg_reg);
                end
            end
            clcd4_pkg::FN_DATA:
            begin
                if (!busy)
                begin
                    taken            = 1'b1;
                    seq_next.extra   = 1'b0;
                    seq_next.in_init = 1'b0;
                    seq_next = start_byte(seq_next, in_byte_reg, 1'b1, cfg_reg);
                end
            end
            clcd4_pkg::FN_CURSOR:
            begin
                if (!busy)
                begin
                    taken            = 1'b1;
                    seq_next.extra   = 1'b0;
                    seq_next.in_init = 1'b0;
                    seq_next = start_byte(seq_next, cursor_addr, 1'b0, cfg_reg);
                end
            end
            clcd4_pkg::FN_CLEAR:
            begin
                if (!busy)
                begin
                    // Clear needs a second settle period
                    taken            = 1'b1;
                    seq_next.extra   = 1'b1;
                    seq_next.in_init = 1'b0;
                    seq_next = start_byte(seq_next, clcd4_pkg::CMD_CLEAR, 1'b0, cfg_reg);
                end
            end
            clcd4_pkg::FN_INIT:
            begin
                if (!busy)
                begin
                    // RS stays low for the whole power-up program
                    taken            = 1'b1;
                    seq_next.extra   = 1'b0;
                    seq_next.in_init = 1'b1;
                    seq_next.pins    = 6'd0;
                    seq_next = enter_step(seq_next, 4'd0, cfg_reg);
                end
            end
            default:
            begin
                // Undefined codes: drop, report not taken
                seq_next = seq_reg;
            end
        endcase

        out_data_next = {taken, (seq_next.phase != PH_IDLE), seq_next.pins[3:0],
                         seq_next.pins[4], seq_next.pins[5]};
    end

    // ------------------------------------------------------------------
    // Timing registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on <= clcd4_pkg::POWER_ON_RST;
            cfg_reg.en_high  <= clcd4_pkg::EN_HIGH_RST;
            cfg_reg.en_low   <= clcd4_pkg::EN_LOW_RST;
            cfg_reg.settle   <= clcd4_pkg::SETTLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (clcd4_pkg::reg_idx_t'(cfg_index))
                clcd4_pkg::REG_POWER_ON: cfg_reg.power_on <= cfg_data;
                clcd4_pkg::REG_EN_HIGH:  cfg_reg.en_high  <= cfg_data[3:0];
                clcd4_pkg::REG_EN_LOW:   cfg_reg.en_low   <= cfg_data[3:0];
                clcd4_pkg::REG_SETTLE:   cfg_reg.settle   <= cfg_data[3:0];
                default:                 cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage, sequencer state and result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            seq_reg     <= '{phase: PH_IDLE, count: 8'd0, byte_val: 8'd0, step: 4'd0,
                             in_init: 1'b0, extra: 1'b0, pins: 6'd0};
        end
        else
        begin
            // Capture a new item whenever the input stage frees up
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            // Hand the held item to the result stage and commit its update
            if (advance_en)
            begin
                out_vld_reg <= in_vld_reg;
                if (in_vld_reg)
                begin
                    seq_reg <= seq_next;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= clcd4_pkg::func_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
            in_row_reg  <= s_tdata[8];
            in_col_reg  <= s_tdata[14:9];
        end
        if (advance_en && in_vld_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clcd4_checker.sv @@
// ----------------------------------------------------------------------------
// clcd4_checker
// Port-level checks of the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_4bit_interface_macros.svh"

module clcd4_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [clcd4_pkg::M_DATA_W-1:0]  m_tdata
);

    logic res_rs;
    logic res_en;
    logic res_busy;
    logic res_taken;

    assign res_rs    = m_tdata[0];
    assign res_en    = m_tdata[1];
    assign res_busy  = m_tdata[6];
    assign res_taken = m_tdata[7];

    // A taken request always leaves a sequence running
    `CLCD4_ASSERT_SAME(a_taken_busy, clk, rst_n, m_tvalid && res_taken, res_busy)

    // Once idle, the enable strobe is low
    `CLCD4_ASSERT_SAME(a_idle_en_low, clk, rst_n, m_tvalid && !res_busy, !res_en)

    // A taken data byte starts with its strobe high
    `CLCD4_ASSERT_SAME(a_data_strobe, clk, rst_n, m_tvalid && res_taken && res_rs, res_en)

    // Hold a stalled result
    `CLCD4_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                       m_tvalid && $stable(m_tdata))

endmodule

bind char_lcd_4bit_interface clcd4_checker u_clcd4_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: 4-bit character LCD pin sequencer bench
// Drives a short table of tick and request items, then random request and
// tick sequences under several timing register settings with random gaps
// on both streams. Predicts the pin levels, busy and accepted flags of every
// item and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import clcd4_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned MAX_REPORTS  = 40;

    // Function codes the block must ignore
    localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 3'd7;

    localparam logic [7:0] WAKE_CMDS [4] = '{CMD_FUNC_SET, CMD_DISP_ON, CMD_ENTRY, CMD_CLEAR};

    // Result fields, laid out like m_tdata from bit 7 down to bit 0
    typedef struct packed {
        logic       accepted;
        logic       busy;
        logic [3:0] nibble;
        logic       en;
        logic       rs;
    } lcd_result_t;

    localparam lcd_result_t NO_WANT = '0;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_HI_ENH,
        SQ_HI_ENL,
        SQ_LO_ENH,
        SQ_LO_ENL,
        SQ_SETTLE,
        SQ_INIT_WAIT,
        SQ_INIT_ENH,
        SQ_INIT_ENL
    } seq_phase_e;

    // One row of the directed table; want is {accepted, busy, nibble, en, rs}
    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [7:0]        bv;
        logic              rw;
        logic [5:0]        cl;
        logic [7:0]        reps;
        logic              typed;
        logic [7:0]        want;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 22;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{FN_TICK,     8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'h00}, // tick while idle
        '{FN_UNDEF_LO, 8'hFF, 1'b1, 6'd63, 8'd1,   1'b1, 8'h00}, // unknown code, idle
        '{FN_CMD,      8'hA5, 1'b0, 6'd0,  8'd1,   1'b1, 8'hEA},
        '{FN_CMD,      8'h00, 1'b1, 6'd0,  8'd1,   1'b1, 8'h6A}, // refused, busy
        '{FN_UNDEF_HI, 8'hFF, 1'b1, 6'd63, 8'd1,   1'b1, 8'h6A}, // unknown code, busy
        '{FN_TICK,     8'h5A, 1'b1, 6'd42, 8'd6,   1'b0, 8'h00},
        '{FN_DATA,     8'hFF, 1'b1, 6'd63, 8'd1,   1'b1, 8'hFF},
        '{FN_TICK,     8'hC3, 1'b0, 6'd21, 8'd6,   1'b0, 8'h00},
        '{FN_CURSOR,   8'h00, 1'b1, 6'd63, 8'd1,   1'b1, 8'hFE}, // second row, last column
        '{FN_TICK,     8'h00, 1'b0, 6'd0,  8'd6,   1'b0, 8'h00},
        '{FN_CURSOR,   8'hFF, 1'b0, 6'd0,  8'd1,   1'b1, 8'hE2}, // top row, first column
        '{FN_TICK,     8'hFF, 1'b1, 6'd63, 8'd6,   1'b0, 8'h00},
        '{FN_DATA,     8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'hC3},
        '{FN_TICK,     8'h00, 1'b0, 6'd0,  8'd6,   1'b0, 8'h00},
        '{FN_CLEAR,    8'h77, 1'b0, 6'd5,  8'd1,   1'b1, 8'hC2},
        '{FN_CLEAR,    8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'h42}, // refused, busy
        '{FN_TICK,     8'h00, 1'b0, 6'd0,  8'd8,   1'b0, 8'h00}, // clear settles twice
        '{FN_INIT,     8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'hC0},
        '{FN_DATA,     8'h55, 1'b0, 6'd0,  8'd1,   1'b1, 8'h40}, // refused during init
        '{FN_INIT,     8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'h40}, // refused during init
        '{FN_TICK,     8'h99, 1'b1, 6'd33, 8'd120, 1'b0, 8'h00}, // run init to the end
        '{FN_TICK,     8'h00, 1'b0, 6'd0,  8'd1,   1'b1, 8'h04}  // pins hold after init
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    reg_idx_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Side band that travels with each item: a typed expectation, if any
    logic        item_typed;
    lcd_result_t item_want;

    // Predictor copy of the timing registers
    logic [7:0] cfg_power_on = POWER_ON_RST;
    logic [3:0] cfg_en_high  = EN_HIGH_RST;
    logic [3:0] cfg_en_low   = EN_LOW_RST;
    logic [3:0] cfg_settle   = SETTLE_RST;

    // Predictor copy of the sequencer
    seq_phase_e ph          = SQ_IDLE;
    logic [7:0] ticks_left  = '0;
    logic [7:0] shift_byte  = '0;
    logic [3:0] init_idx    = '0;
    logic       init_run    = 1'b0;
    logic       clear_hold  = 1'b0;
    logic       rs_pin      = 1'b0;
    logic       en_pin      = 1'b0;
    logic [3:0] data_pins   = '0;

    lcd_result_t pin_queue [$];

    int unsigned n_driven    = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned n_taken     = 0;
    int unsigned n_refused   = 0;
    int unsigned n_ticks     = 0;
    int unsigned n_reg_write = 0;
    bit          no_gaps     = 1'b0;

    char_lcd_4bit_interface i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sequencer predictor
    // ------------------------------------------------------------------------

    // A count register that holds zero behaves as one
    function automatic logic [7:0] load_count(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic void load_byte(input logic [7:0] b, input logic rs);
        shift_byte = b;
        rs_pin     = rs;
        en_pin     = 1'b1;
        data_pins  = b[7:4];
        ph         = SQ_HI_ENH;
        ticks_left = load_count({4'd0, cfg_en_high});
    endfunction

    function automatic void load_wait(input logic [7:0] n);
        ph         = SQ_INIT_WAIT;
        ticks_left = load_count(n);
    endfunction

    function automatic void load_wake_nibble(input logic [3:0] n);
        data_pins  = n;
        en_pin     = 1'b1;
        ph         = SQ_INIT_ENH;
        ticks_left = load_count({4'd0, cfg_en_high});
    endfunction

    // Enter one step of the power-up program; past the last step go idle
    function automatic void init_goto(input logic [3:0] s);
        init_idx = s;
        case (s)
            4'd0:                      load_wait(cfg_power_on);
            4'd1, 4'd3, 4'd5:          load_wake_nibble(NIB_WAKE);
            4'd2:                      load_wait(WAIT_WAKE1);
            4'd4:                      load_wait(WAIT_WAKE2);
            4'd6:                      load_wake_nibble(NIB_4BIT);
            4'd7, 4'd8, 4'd9, 4'd10:   load_byte(WAKE_CMDS[2'(s - 4'd7)], 1'b0);
            4'd11:                     load_wait({4'd0, cfg_settle});
            default:
            begin
                init_run   = 1'b0;
                init_idx   = '0;
                ph         = SQ_IDLE;
                ticks_left = '0;
            end
        endcase
    endfunction

    // Move to the next step once the current count has run out
    function automatic void step_time();
        case (ph)
            SQ_HI_ENH:
            begin
                en_pin     = 1'b0;
                ph         = SQ_HI_ENL;
                ticks_left = load_count({4'd0, cfg_en_low});
            end
            SQ_HI_ENL:
            begin
                data_pins  = shift_byte[3:0];
                en_pin     = 1'b1;
                ph         = SQ_LO_ENH;
                ticks_left = load_count({4'd0, cfg_en_high});
            end
            SQ_LO_ENH:
            begin
                en_pin     = 1'b0;
                ph         = SQ_LO_ENL;
                ticks_left = load_count({4'd0, cfg_en_low});
            end
            SQ_LO_ENL:
            begin
                ph         = SQ_SETTLE;
                ticks_left = load_count({4'd0, cfg_settle});
            end
            SQ_SETTLE:
            begin
                if (clear_hold)
                begin
                    clear_hold = 1'b0;
                    ticks_left = load_count({4'd0, cfg_settle});
                end
                else if (init_run)
                    init_goto(init_idx + 4'd1);
                else
                begin
                    ph         = SQ_IDLE;
                    ticks_left = '0;
                end
            end
            SQ_INIT_ENH:
            begin
                en_pin     = 1'b0;
                ph         = SQ_INIT_ENL;
                ticks_left = load_count({4'd0, cfg_en_low});
            end
            SQ_INIT_WAIT, SQ_INIT_ENL:
                init_goto(init_idx + 4'd1);
            default:
            begin
                ph         = SQ_IDLE;
                ticks_left = '0;
                init_run   = 1'b0;
            end
        endcase
    endfunction

    // Apply one item to the predictor and return the pins after it
    function automatic lcd_result_t lcd_pins_after(input logic [FUNC_W-1:0] fn,
                                                   input logic [7:0] bv,
                                                   input logic rw,
                                                   input logic [5:0] cl);
        logic        busy;
        logic        taken;
        lcd_result_t res;
        busy  = (ph != SQ_IDLE);
        taken = 1'b0;
        if (fn == FN_TICK)
        begin
            if (busy)
            begin
                ticks_left = ticks_left - 8'd1;
                if (ticks_left == 8'd0)
                    step_time();
            end
        end
        else if (!busy && fn <= FN_INIT)
        begin
            taken      = 1'b1;
            clear_hold = 1'b0;
            init_run   = 1'b0;
            case (fn)
                FN_CMD:    load_byte(bv, 1'b0);
                FN_DATA:   load_byte(bv, 1'b1);
                FN_CURSOR: load_byte((rw ? ROW1_BASE : ROW0_BASE) + {2'd0, cl}, 1'b0);
                FN_CLEAR:
                begin
                    clear_hold = 1'b1;
                    load_byte(CMD_CLEAR, 1'b0);
                end
                default:
                begin
                    init_run  = 1'b1;
                    rs_pin    = 1'b0;
                    en_pin    = 1'b0;
                    data_pins = '0;
                    init_goto(4'd0);
                end
            endcase
        end
        res.accepted = taken;
        res.busy     = (ph != SQ_IDLE);
        res.nibble   = data_pins;
        res.en       = en_pin;
        res.rs       = rs_pin;
        return res;
    endfunction

    function automatic void apply_reg(input reg_idx_t idx, input logic [7:0] val);
        case (idx)
            REG_POWER_ON: cfg_power_on = val;
            REG_EN_HIGH:  cfg_en_high  = val[3:0];
            REG_EN_LOW:   cfg_en_low   = val[3:0];
            default:      cfg_settle   = val[3:0];
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_error(input string msg);
        if (n_errors < MAX_REPORTS)
            $display("ERROR result %0d: %s", n_results, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // Check result transfers first, then queue the prediction for an accepted
    // item; both sample the values that stood before this edge.
    always @(posedge clk)
    begin : scoreboard
        lcd_result_t got;
        lcd_result_t want;
        lcd_result_t nxt;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = lcd_result_t'(m_tdata);
                if (pin_queue.size() == 0)
                    flag_error("result transfer with no prediction pending");
                else
                begin
                    want = pin_queue.pop_front();
                    check_field("rs_level",     want.rs,       got.rs);
                    check_field("en_level",     want.en,       got.en);
                    check_field("nibble_lines", want.nibble,   got.nibble);
                    check_field("busy_res",     want.busy,     got.busy);
                    check_field("accepted",     want.accepted, got.accepted);
                end
                n_results++;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                n_reg_write++;
            end
            if (s_tvalid && s_tready)
            begin
                nxt = lcd_pins_after(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[14:9]);
                if (s_tuser == FN_TICK)
                    n_ticks++;
                else if (nxt.accepted)
                    n_taken++;
                else
                    n_refused++;
                // A typed table row overrides the computed pins
                pin_queue.push_back(item_typed ? item_want : nxt);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes short pauses, rarely long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Hold the item until its transfer; leave tvalid high for the next call
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [7:0] bv,
                             input logic rw, input logic [5:0] cl,
                             input logic typed, input lcd_result_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= fn;
        s_tdata    <= {1'b0, cl, rw, bv};
        item_typed <= typed;
        item_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_driven++;
    endtask

    task automatic send_random_fields(input logic [FUNC_W-1:0] fn);
        send_item(fn, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  6'($urandom_range(0, 63)), 1'b0, NO_WANT);
    endtask

    // Drop tvalid and hold until every accepted item has its result back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_results != n_driven)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_reg_value(input reg_idx_t idx);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return (idx == REG_POWER_ON) ? 8'd255 : 8'd15;
        return (idx == REG_POWER_ON) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 3));
    endfunction

    // Extremes first (all max, all zero, all one), then random subsets
    task automatic configure_phase(input int unsigned p);
        reg_idx_t idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            case (p)
                0: write_reg(idx, (idx == REG_POWER_ON) ? 8'd255 : 8'd15);
                1: write_reg(idx, 8'd0);
                2: write_reg(idx, 8'd1);
                default:
                    if ($urandom_range(0, 1) == 1)
                        write_reg(idx, pick_reg_value(idx));
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Rough tick count a request keeps the sequencer busy
    function automatic int unsigned sequence_ticks(input logic [FUNC_W-1:0] fn);
        int unsigned one_byte;
        one_byte = 2 * (load_count({4'd0, cfg_en_high}) + load_count({4'd0, cfg_en_low}))
                 + load_count({4'd0, cfg_settle});
        case (fn)
            FN_CLEAR: return one_byte + load_count({4'd0, cfg_settle});
            FN_INIT:  return load_count(cfg_power_on) + 6
                           + 4 * (load_count({4'd0, cfg_en_high}) + load_count({4'd0, cfg_en_low}))
                           + 4 * one_byte + load_count({4'd0, cfg_settle});
            default:  return one_byte;
        endcase
    endfunction

    // One request followed by roughly enough ticks to finish it; sometimes
    // cut short, with stray requests mixed in to hit the busy refusal.
    task automatic random_op();
        int unsigned pick;
        int unsigned n;
        logic [FUNC_W-1:0] fn;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_random_fields(FUNC_W'($urandom_range(0, 7)));
            return;
        end
        fn = (pick < 38) ? FN_CMD :
             (pick < 68) ? FN_DATA :
             (pick < 83) ? FN_CURSOR :
             (pick < 93) ? FN_CLEAR : FN_INIT;
        n = sequence_ticks(fn);
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, n);
        else
            n = n + $urandom_range(0, 3);
        send_random_fields(fn);
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_random_fields(FUNC_W'($urandom_range(1, 7)));
            else
                send_random_fields(FN_TICK);
        end
    endtask

    // Result side: ready runs broken by random stalls
    initial
    begin : result_sink
        int unsigned run_len;
        int unsigned stall_len;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 16);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = pick_gap();
            if (stall_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results of %0d", CYCLE_LIMIT, n_results,
                 n_driven);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned target;
        int unsigned p;
        int unsigned ops;
        dir_row_t    row_now;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= FN_TICK;
        item_typed <= 1'b0;
        item_want  <= NO_WANT;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_POWER_ON;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset timing values
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row_now = DIR_TABLE[r];
            for (int unsigned k = 0; k < row_now.reps; k++)
                send_item(row_now.fn, row_now.bv, row_now.rw, row_now.cl,
                          row_now.typed && (k == 0), lcd_result_t'(row_now.want));
        end

        // Random phases, each under its own register setting
        target = n_driven + RANDOM_ITEMS;
        p = 0;
        while (n_driven < target)
        begin
            wait_drain();
            configure_phase(p);
            no_gaps = ($urandom_range(0, 3) == 0);
            ops = (p == 0) ? 3 : $urandom_range(4, 12);
            repeat (ops) random_op();
            p++;
        end

        wait_drain();
        // Catch any stray result behind the two-stage pipeline
        repeat (12) @(posedge clk);
        if (pin_queue.size() != 0)
            flag_error($sformatf("%0d predictions left without a result", pin_queue.size()));

        $display("Covered %0d items over %0d register phases: %0d requests taken, %0d refused,",
                 n_driven, p, n_taken, n_refused);
        $display("%0d ticks, %0d register writes, %0d results checked, %0d errors",
                 n_ticks, n_reg_write, n_results, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/clcd4_pkg.sv
rtl/char_lcd_4bit_interface.sv
rtl/clcd4_checker.sv
bench/tb_top.sv
